FILE: src/segment_intersection_unit_defines.svh
// ---------------------------------------------------------------------------
// Segment intersection unit: assertion macros
// Shared concurrent check forms, clocked on the rising edge, held off in reset.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication
`define SEGX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEGX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/segx_pkg.sv
// ---------------------------------------------------------------------------
// Segment intersection package
// Fixed widths and result status codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package segx_pkg;

   localparam int FIELD_BITS = 16;   // width of a coordinate port
   localparam int OUT_BITS   = 48;   // fixed point result width
   localparam int THR_BITS   = 21;   // zero threshold register width

   typedef enum logic [1:0] {
      ST_PARALLEL      = 2'd0,
      ST_CROSS_OUTSIDE = 2'd1,
      ST_INTERSECT     = 2'd2
   } status_type;

endpackage

FILE: src/segment_intersection_unit.sv
// ---------------------------------------------------------------------------
// Segment intersection unit
// Crossing point of two 2D segments in signed fixed point, fully pipelined.
// ---------------------------------------------------------------------------
// One beat in, one beat out, every cycle while no result beat is held at the
// output. The pipe is 59 register stages: ten front stages (capture,
// difference, cross products, den/na/nb, normalise, split multiply, combine,
// sum, dividend set-up, divider entry) then a 48-stage restoring divider
// producing one quotient bit per stage, then the saturation/sign output
// register. The whole pipe advances together; req_stall is raised only while a
// result beat sits stalled at the output, so throughput is one segment pair
// per clock while the output is not stalled.
`timescale 1ns / 1ps

`include "segment_intersection_unit_defines.svh"

module segment_intersection_unit
   import segx_pkg::*;
#(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_wr_en,
   input  logic [THR_BITS-1:0]          csr_wr_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [FIELD_BITS-1:0] req_first_start_x,
   input  logic signed [FIELD_BITS-1:0] req_first_start_y,
   input  logic signed [FIELD_BITS-1:0] req_first_end_x,
   input  logic signed [FIELD_BITS-1:0] req_first_end_y,
   input  logic signed [FIELD_BITS-1:0] req_second_start_x,
   input  logic signed [FIELD_BITS-1:0] req_second_start_y,
   input  logic signed [FIELD_BITS-1:0] req_second_end_x,
   input  logic signed [FIELD_BITS-1:0] req_second_end_y,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [OUT_BITS-1:0]   rsp_cross_x,
   output logic signed [OUT_BITS-1:0]   rsp_cross_y,
   output logic                         rsp_clipped
);

   localparam int C    = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int FW   = (C > FIELD_BITS) ? C : FIELD_BITS;
   localparam int DFW  = C + 1;            // coordinate differences
   localparam int PRW  = 2 * C + 2;        // difference products
   localparam int DW   = 2 * C + 3;        // den, na, nb
   localparam int HW   = C + 2;            // low split of den / na
   localparam int HIW  = DW - HW;          // high split
   localparam int NW   = 3 * C + 5;        // crossing numerator
   localparam int MW   = (DW > THR_BITS) ? DW : THR_BITS;
   localparam int DVW  = NW + F;           // rounded dividend
   localparam int PW   = DVW + OUT_BITS;   // divider word, dividend at the bottom
   localparam int NST  = OUT_BITS;         // divider stages
   localparam logic [OUT_BITS-1:0] LIM_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] LIM_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

   // whole pipe moves unless the output beat is held
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // zero threshold register
   logic [THR_BITS-1:0] thr_ff;
   logic [MW-1:0]       thr_eff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_BITS'(1);
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end
   assign thr_eff = (thr_ff == '0) ? MW'(1) : MW'(thr_ff);

   // ---------------- stage 0: capture and resize to the coordinate width ----------------
   logic                v0_ff;
   logic signed [C-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;

   function automatic logic signed [C-1:0] coord(input logic [FIELD_BITS-1:0] f);
      logic [FW-1:0] z;
      z = FW'(f);
      return $signed(z[C-1:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= coord(req_first_start_x);
         y1_ff <= coord(req_first_start_y);
         x2_ff <= coord(req_first_end_x);
         y2_ff <= coord(req_first_end_y);
         x3_ff <= coord(req_second_start_x);
         y3_ff <= coord(req_second_start_y);
         x4_ff <= coord(req_second_end_x);
         y4_ff <= coord(req_second_end_y);
      end
   end

   // ---------------- stage 1: differences ----------------
   logic                  v1_ff;
   logic signed [C-1:0]   s1_x1_ff, s1_y1_ff;
   logic signed [DFW-1:0] dx12_ff, dy12_ff, dx34_ff, dy34_ff, ex_ff, ey_ff;
   logic signed [DFW-1:0] sx_ff, sy_ff;   // first segment endpoint sums

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x1_ff <= x1_ff;
         s1_y1_ff <= y1_ff;
         dx12_ff  <= DFW'(x2_ff) - DFW'(x1_ff);
         dy12_ff  <= DFW'(y2_ff) - DFW'(y1_ff);
         dx34_ff  <= DFW'(x4_ff) - DFW'(x3_ff);
         dy34_ff  <= DFW'(y4_ff) - DFW'(y3_ff);
         ex_ff    <= DFW'(x1_ff) - DFW'(x3_ff);
         ey_ff    <= DFW'(y1_ff) - DFW'(y3_ff);
         sx_ff    <= DFW'(x1_ff) + DFW'(x2_ff);
         sy_ff    <= DFW'(y1_ff) + DFW'(y2_ff);
      end
   end

   // ---------------- stage 2: cross product terms ----------------
   logic                  v2_ff;
   logic signed [C-1:0]   s2_x1_ff, s2_y1_ff;
   logic signed [DFW-1:0] s2_dx12_ff, s2_dy12_ff, s2_sx_ff, s2_sy_ff;
   logic signed [PRW-1:0] pa_ff, pb_ff, pc_ff, pd_ff, pe_ff, pf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;
         s2_dx12_ff <= dx12_ff;
         s2_dy12_ff <= dy12_ff;
         s2_sx_ff   <= sx_ff;
         s2_sy_ff   <= sy_ff;
         pa_ff      <= dy34_ff * dx12_ff;
         pb_ff      <= dx34_ff * dy12_ff;
         pc_ff      <= dx34_ff * ey_ff;
         pd_ff      <= dy34_ff * ex_ff;
         pe_ff      <= dx12_ff * ey_ff;
         pf_ff      <= dy12_ff * ex_ff;
      end
   end

   // ---------------- stage 3: den, na, nb ----------------
   logic                  v3_ff;
   logic signed [C-1:0]   s3_x1_ff, s3_y1_ff;
   logic signed [DFW-1:0] s3_dx12_ff, s3_dy12_ff, s3_sx_ff, s3_sy_ff;
   logic signed [DW-1:0]  den_ff, na_ff, nb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_x1_ff   <= s2_x1_ff;
         s3_y1_ff   <= s2_y1_ff;
         s3_dx12_ff <= s2_dx12_ff;
         s3_dy12_ff <= s2_dy12_ff;
         s3_sx_ff   <= s2_sx_ff;
         s3_sy_ff   <= s2_sy_ff;
         den_ff     <= DW'(pa_ff) - DW'(pb_ff);
         na_ff      <= DW'(pc_ff) - DW'(pd_ff);
         nb_ff      <= DW'(pe_ff) - DW'(pf_ff);
      end
   end

   // ---------------- stage 4: zero tests, sign normalise, status ----------------
   logic [DW-1:0]        den_mag, na_mag, nb_mag;
   logic                 den_zero, coin_in, par_in, outside;
   logic signed [DW-1:0] dn_in, nan_in, nbn_in;
   logic [1:0]           status_in;

   always_comb begin
      den_mag  = den_ff[DW-1] ? DW'(-den_ff) : DW'(den_ff);
      na_mag   = na_ff[DW-1]  ? DW'(-na_ff)  : DW'(na_ff);
      nb_mag   = nb_ff[DW-1]  ? DW'(-nb_ff)  : DW'(nb_ff);
      den_zero = MW'(den_mag) < thr_eff;
      coin_in  = den_zero && (MW'(na_mag) < thr_eff) && (MW'(nb_mag) < thr_eff);
      par_in   = den_zero && !coin_in;
      dn_in    = den_ff[DW-1] ? -den_ff : den_ff;
      nan_in   = den_ff[DW-1] ? -na_ff  : na_ff;
      nbn_in   = den_ff[DW-1] ? -nb_ff  : nb_ff;
      outside  = nan_in[DW-1] || (nan_in > dn_in) || nbn_in[DW-1] || (nbn_in > dn_in);
      if (par_in) begin
         status_in = ST_PARALLEL;
      end else if (coin_in || !outside) begin
         status_in = ST_INTERSECT;
      end else begin
         status_in = ST_CROSS_OUTSIDE;
      end
   end

   logic                  v4_ff, coin4_ff, par4_ff;
   logic [1:0]            st4_ff;
   logic signed [C-1:0]   s4_x1_ff, s4_y1_ff;
   logic signed [DFW-1:0] s4_dx12_ff, s4_dy12_ff, s4_sx_ff, s4_sy_ff;
   logic signed [DW-1:0]  dn4_ff, na4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         coin4_ff   <= coin_in;
         par4_ff    <= par_in;
         st4_ff     <= status_in;
         s4_x1_ff   <= s3_x1_ff;
         s4_y1_ff   <= s3_y1_ff;
         s4_dx12_ff <= s3_dx12_ff;
         s4_dy12_ff <= s3_dy12_ff;
         s4_sx_ff   <= s3_sx_ff;
         s4_sy_ff   <= s3_sy_ff;
         dn4_ff     <= dn_in;
         na4_ff     <= nan_in;
      end
   end

   // ---------------- stage 5: split partial products ----------------
   logic [HW-1:0]          dn_lo, na_lo;
   logic signed [HIW-1:0]  dn_hi, na_hi;
   assign dn_lo = dn4_ff[HW-1:0];
   assign dn_hi = $signed(dn4_ff[DW-1:HW]);
   assign na_lo = na4_ff[HW-1:0];
   assign na_hi = $signed(na4_ff[DW-1:HW]);

   logic                      v5_ff, coin5_ff, par5_ff;
   logic [1:0]                st5_ff;
   logic signed [DFW-1:0]     s5_sx_ff, s5_sy_ff;
   logic [DW-1:0]             dn5_ff;
   logic signed [C+HW:0]      pxl_ff, pyl_ff;     // x1 * den low
   logic signed [C+HIW-1:0]   pxh_ff, pyh_ff;     // x1 * den high
   logic signed [HW+DFW:0]    qxl_ff, qyl_ff;     // na low * dx12
   logic signed [HIW+DFW-1:0] qxh_ff, qyh_ff;     // na high * dx12

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         coin5_ff <= coin4_ff;
         par5_ff  <= par4_ff;
         st5_ff   <= st4_ff;
         s5_sx_ff <= s4_sx_ff;
         s5_sy_ff <= s4_sy_ff;
         dn5_ff   <= DW'(dn4_ff);
         pxl_ff   <= s4_x1_ff * $signed({1'b0, dn_lo});
         pyl_ff   <= s4_y1_ff * $signed({1'b0, dn_lo});
         pxh_ff   <= s4_x1_ff * dn_hi;
         pyh_ff   <= s4_y1_ff * dn_hi;
         qxl_ff   <= $signed({1'b0, na_lo}) * s4_dx12_ff;
         qyl_ff   <= $signed({1'b0, na_lo}) * s4_dy12_ff;
         qxh_ff   <= na_hi * s4_dx12_ff;
         qyh_ff   <= na_hi * s4_dy12_ff;
      end
   end

   // ---------------- stage 6: recombine partial products ----------------
   logic                 v6_ff, coin6_ff, par6_ff;
   logic [1:0]           st6_ff;
   logic signed [DFW-1:0] s6_sx_ff, s6_sy_ff;
   logic [DW-1:0]        dn6_ff;
   logic signed [NW-1:0] ax_ff, ay_ff, bx_ff, by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         coin6_ff <= coin5_ff;
         par6_ff  <= par5_ff;
         st6_ff   <= st5_ff;
         s6_sx_ff <= s5_sx_ff;
         s6_sy_ff <= s5_sy_ff;
         dn6_ff   <= dn5_ff;
         ax_ff    <= (NW'(pxh_ff) <<< HW) + NW'(pxl_ff);
         ay_ff    <= (NW'(pyh_ff) <<< HW) + NW'(pyl_ff);
         bx_ff    <= (NW'(qxh_ff) <<< HW) + NW'(qxl_ff);
         by_ff    <= (NW'(qyh_ff) <<< HW) + NW'(qyl_ff);
      end
   end

   // ---------------- stage 7: numerator sum, coincident override ----------------
   logic                 v7_ff, par7_ff;
   logic [1:0]           st7_ff;
   logic [DW-1:0]        dv7_ff;
   logic signed [NW-1:0] numx7_ff, numy7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         par7_ff <= par6_ff;
         st7_ff  <= st6_ff;
         if (coin6_ff) begin
            // midpoint of the first segment: sum over two
            numx7_ff <= NW'(s6_sx_ff);
            numy7_ff <= NW'(s6_sy_ff);
            dv7_ff   <= DW'(2);
         end else begin
            numx7_ff <= ax_ff + bx_ff;
            numy7_ff <= ay_ff + by_ff;
            dv7_ff   <= dn6_ff;
         end
      end
   end

   // ---------------- stage 8: magnitude, scale, round-half bias ----------------
   logic          v8_ff, par8_ff, negx8_ff, negy8_ff;
   logic [1:0]    st8_ff;
   logic [DW-1:0] dv8_ff;
   logic [PW-1:0] dx8_ff, dy8_ff;
   logic [NW-1:0] magx, magy;

   assign magx = numx7_ff[NW-1] ? NW'(-numx7_ff) : NW'(numx7_ff);
   assign magy = numy7_ff[NW-1] ? NW'(-numy7_ff) : NW'(numy7_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         par8_ff  <= par7_ff;
         st8_ff   <= st7_ff;
         dv8_ff   <= dv7_ff;
         negx8_ff <= numx7_ff[NW-1];
         negy8_ff <= numy7_ff[NW-1];
         dx8_ff   <= (PW'(magx) << F) + PW'(dv7_ff >> 1);
         dy8_ff   <= (PW'(magy) << F) + PW'(dv7_ff >> 1);
      end
   end

   // ---------------- stage 9: overflow test, divider entry ----------------
   // quotient bits above the 48 kept ones are nonzero when the high part
   // of the dividend already reaches the divisor
   logic [DVW-1:0] hix, hiy;
   logic           ovfx, ovfy;
   assign hix  = dx8_ff[PW-1:OUT_BITS];
   assign hiy  = dy8_ff[PW-1:OUT_BITS];
   assign ovfx = hix >= DVW'(dv8_ff);
   assign ovfy = hiy >= DVW'(dv8_ff);

   logic                dv_valid_ff [0:NST];
   logic                dv_par_ff   [0:NST];
   logic [1:0]          dv_st_ff    [0:NST];
   logic [DW-1:0]       dv_den_ff   [0:NST];
   logic [DW-1:0]       dv_remx_ff  [0:NST];
   logic [DW-1:0]       dv_remy_ff  [0:NST];
   logic [OUT_BITS-1:0] dv_wx_ff    [0:NST];
   logic [OUT_BITS-1:0] dv_wy_ff    [0:NST];
   logic                dv_negx_ff  [0:NST];
   logic                dv_negy_ff  [0:NST];
   logic                dv_ovfx_ff  [0:NST];
   logic                dv_ovfy_ff  [0:NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_valid_ff[0] <= v8_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_par_ff[0]  <= par8_ff;
         dv_st_ff[0]   <= st8_ff;
         dv_den_ff[0]  <= dv8_ff;
         dv_remx_ff[0] <= ovfx ? '0 : hix[DW-1:0];
         dv_remy_ff[0] <= ovfy ? '0 : hiy[DW-1:0];
         dv_wx_ff[0]   <= dx8_ff[OUT_BITS-1:0];
         dv_wy_ff[0]   <= dy8_ff[OUT_BITS-1:0];
         dv_negx_ff[0] <= negx8_ff;
         dv_negy_ff[0] <= negy8_ff;
         dv_ovfx_ff[0] <= ovfx;
         dv_ovfy_ff[0] <= ovfy;
      end
   end

   // ---------------- divider: one restoring step per stage ----------------
   // the word shifts the dividend bits out at the top and the quotient
   // bits in at the bottom
   for (genvar k = 0; k < NST; k++) begin : g_div
      logic [DW:0] tx, ty;
      logic        gex, gey;
      assign tx  = {dv_remx_ff[k], dv_wx_ff[k][OUT_BITS-1]};
      assign ty  = {dv_remy_ff[k], dv_wy_ff[k][OUT_BITS-1]};
      assign gex = tx >= {1'b0, dv_den_ff[k]};
      assign gey = ty >= {1'b0, dv_den_ff[k]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[k+1] <= dv_valid_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_par_ff[k+1]  <= dv_par_ff[k];
            dv_st_ff[k+1]   <= dv_st_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_remx_ff[k+1] <= gex ? DW'(tx - {1'b0, dv_den_ff[k]}) : tx[DW-1:0];
            dv_remy_ff[k+1] <= gey ? DW'(ty - {1'b0, dv_den_ff[k]}) : ty[DW-1:0];
            dv_wx_ff[k+1]   <= {dv_wx_ff[k][OUT_BITS-2:0], gex};
            dv_wy_ff[k+1]   <= {dv_wy_ff[k][OUT_BITS-2:0], gey};
            dv_negx_ff[k+1] <= dv_negx_ff[k];
            dv_negy_ff[k+1] <= dv_negy_ff[k];
            dv_ovfx_ff[k+1] <= dv_ovfx_ff[k];
            dv_ovfy_ff[k+1] <= dv_ovfy_ff[k];
         end
      end
   end

   // ---------------- output: saturate, apply sign ----------------
   function automatic logic [OUT_BITS:0] finish(input logic [OUT_BITS-1:0] q,
                                                input logic neg, input logic ovf);
      logic                clip;
      logic [OUT_BITS-1:0] v;
      clip = ovf || (neg ? (q > LIM_NEG) : (q > LIM_POS));
      v    = clip ? (neg ? LIM_NEG : LIM_POS) : q;
      return {clip, neg ? OUT_BITS'(-v) : v};
   endfunction

   logic [OUT_BITS:0] fx, fy;
   assign fx = finish(dv_wx_ff[NST], dv_negx_ff[NST], dv_ovfx_ff[NST]);
   assign fy = finish(dv_wy_ff[NST], dv_negy_ff[NST], dv_ovfy_ff[NST]);

   logic                rsp_valid_ff, rsp_clipped_ff;
   logic [1:0]          rsp_status_ff;
   logic [OUT_BITS-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid_ff[NST];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= dv_st_ff[NST];
         if (dv_par_ff[NST]) begin
            rsp_x_ff       <= '0;
            rsp_y_ff       <= '0;
            rsp_clipped_ff <= 1'b0;
         end else begin
            rsp_x_ff       <= fx[OUT_BITS-1:0];
            rsp_y_ff       <= fy[OUT_BITS-1:0];
            rsp_clipped_ff <= fx[OUT_BITS] || fy[OUT_BITS];
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_cross_x = $signed(rsp_x_ff);
   assign rsp_cross_y = $signed(rsp_y_ff);
   assign rsp_clipped = rsp_clipped_ff;

   // ---------------- checks ----------------
   `SEGX_ASSERT_NEXT(a_entry, clock, reset, req_valid && !req_stall, v0_ff, "accepted beat lost at entry")
   `SEGX_ASSERT_NOW(a_par_zero, clock, reset, rsp_valid && rsp_status == ST_PARALLEL, rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_clipped, "parallel result not zero")
   `SEGX_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_status == ST_PARALLEL || rsp_status == ST_CROSS_OUTSIDE || rsp_status == ST_INTERSECT, "bad status code")
   `SEGX_ASSERT_NEXT(a_hold_pipe, clock, reset, rsp_valid && rsp_stall, $stable(dv_valid_ff[NST]) && $stable(v8_ff), "pipe moved while output held")

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Segment intersection unit testbench
// Sends segment pairs through the unit under random idling and checks every
// result beat against a predictor of the crossing point and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import segx_pkg::*;

   localparam int FRAC = 16;
   localparam int PIPE_CYCLES = 70;   // a little over the unit's latency

   typedef struct {
      logic signed [FIELD_BITS-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   } segment_pair_type;

   typedef struct {
      status_type          status;
      logic [OUT_BITS-1:0] cx;
      logic [OUT_BITS-1:0] cy;
      logic                clipped;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [THR_BITS-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [FIELD_BITS-1:0] req_first_start_x = '0, req_first_start_y = '0;
   logic signed [FIELD_BITS-1:0] req_first_end_x = '0, req_first_end_y = '0;
   logic signed [FIELD_BITS-1:0] req_second_start_x = '0, req_second_start_y = '0;
   logic signed [FIELD_BITS-1:0] req_second_end_x = '0, req_second_end_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [OUT_BITS-1:0] rsp_cross_x, rsp_cross_y;
   logic rsp_clipped;

   segment_pair_type pending_pairs[$];
   crossing_type     expected_crossings[$];
   segment_pair_type beat_on_bus;
   logic [THR_BITS-1:0] zero_thr = THR_BITS'(1);
   int  error_count = 0;
   int  send_gap = 0;
   int  sink_gap = 0;
   int  hold_cycles = 0;
   bit  hold_request = 1'b0;
   bit  hold_taken = 1'b0;
   bit  quiet = 1'b0;

   segment_intersection_unit #(.COORD_BITS(16), .FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_start_x(req_first_start_x), .req_first_start_y(req_first_start_y),
      .req_first_end_x(req_first_end_x), .req_first_end_y(req_first_end_y),
      .req_second_start_x(req_second_start_x), .req_second_start_y(req_second_start_y),
      .req_second_end_x(req_second_end_x), .req_second_end_y(req_second_end_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_cross_x(rsp_cross_x),
      .rsp_cross_y(rsp_cross_y), .rsp_clipped(rsp_clipped)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // rounded quotient num * 2^FRAC / den, saturated to the output width
   function automatic logic [OUT_BITS-1:0] fixed_quotient(
         input logic signed [127:0] num, input longint den, inout logic clip);
      logic neg;
      logic [127:0] mag, q, limit;
      neg = num < 0;
      mag = neg ? -num : num;
      mag = mag << FRAC;
      q = (mag + 128'(den >> 1)) / 128'(den);
      limit = neg ? (128'd1 << (OUT_BITS - 1)) : (128'd1 << (OUT_BITS - 1)) - 128'd1;
      if (q > limit) begin
         q = limit;
         clip = 1'b1;
      end
      return neg ? -q[OUT_BITS-1:0] : q[OUT_BITS-1:0];
   endfunction

   function automatic longint magnitude(input longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic crossing_type predict_crossing(input segment_pair_type p);
      crossing_type r;
      longint dx12, dy12, dx34, dy34, ex, ey, den, na, nb, thr;
      dx12 = longint'(p.x2) - longint'(p.x1); dy12 = longint'(p.y2) - longint'(p.y1);
      dx34 = longint'(p.x4) - longint'(p.x3); dy34 = longint'(p.y4) - longint'(p.y3);
      ex = longint'(p.x1) - longint'(p.x3);   ey = longint'(p.y1) - longint'(p.y3);
      den = dy34 * dx12 - dx34 * dy12;
      na = dx34 * ey - dy34 * ex;
      nb = dx12 * ey - dy12 * ex;
      thr = (zero_thr == '0) ? longint'(1) : longint'(zero_thr);
      r.clipped = 1'b0;
      if (magnitude(den) < thr && magnitude(na) < thr && magnitude(nb) < thr) begin
         // coincident: midpoint of the first segment
         r.status = ST_INTERSECT;
         r.cx = fixed_quotient(128'(longint'(p.x1) + longint'(p.x2)), longint'(2),
                               r.clipped);
         r.cy = fixed_quotient(128'(longint'(p.y1) + longint'(p.y2)), longint'(2),
                               r.clipped);
      end else if (magnitude(den) < thr) begin
         r.status = ST_PARALLEL;
         r.cx = '0;
         r.cy = '0;
      end else begin
         if (den < 0) begin
            den = -den; na = -na; nb = -nb;
         end
         r.cx = fixed_quotient(128'(p.x1) * 128'(den) + 128'(na) * 128'(dx12),
                               den, r.clipped);
         r.cy = fixed_quotient(128'(p.y1) * 128'(den) + 128'(na) * 128'(dy12),
                               den, r.clipped);
         r.status = (na < 0 || na > den || nb < 0 || nb > den) ?
                    ST_CROSS_OUTSIDE : ST_INTERSECT;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // request driver: one beat held until accepted, random gaps between beats
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (req_valid)
               expected_crossings.push_back(predict_crossing(beat_on_bus));
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               beat_on_bus = pending_pairs.pop_front();
               req_first_start_x  <= beat_on_bus.x1;
               req_first_start_y  <= beat_on_bus.y1;
               req_first_end_x    <= beat_on_bus.x2;
               req_first_end_y    <= beat_on_bus.y2;
               req_second_start_x <= beat_on_bus.x3;
               req_second_start_y <= beat_on_bus.y3;
               req_second_end_x   <= beat_on_bus.x4;
               req_second_end_y   <= beat_on_bus.y4;
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 5) == 0)
                  send_gap <= $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: long hold-off on request, otherwise short random bursts
   always @(posedge clock) begin
      if (hold_request && !hold_taken) begin
         hold_taken  <= 1'b1;
         hold_cycles <= 300;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (sink_gap > 0) begin
         sink_gap <= sink_gap - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         sink_gap <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // response monitor
   always @(posedge clock) begin
      crossing_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_crossings.size() == 0) begin
            report_mismatch("result beat with nothing expected");
         end else begin
            e = expected_crossings.pop_front();
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, e.status));
            if (rsp_cross_x !== e.cx)
               report_mismatch($sformatf("cross_x %h, expected %h", rsp_cross_x, e.cx));
            if (rsp_cross_y !== e.cy)
               report_mismatch($sformatf("cross_y %h, expected %h", rsp_cross_y, e.cy));
            if (rsp_clipped !== e.clipped)
               report_mismatch($sformatf("clipped %b, expected %b", rsp_clipped, e.clipped));
         end
      end
   end

   function automatic segment_pair_type make_pair(input int a, b, c, d, e, f, g, h);
      segment_pair_type p;
      p.x1 = FIELD_BITS'(a); p.y1 = FIELD_BITS'(b);
      p.x2 = FIELD_BITS'(c); p.y2 = FIELD_BITS'(d);
      p.x3 = FIELD_BITS'(e); p.y3 = FIELD_BITS'(f);
      p.x4 = FIELD_BITS'(g); p.y4 = FIELD_BITS'(h);
      return p;
   endfunction

   // random pair: mostly well-formed geometry, some raw noise
   function automatic segment_pair_type random_pair();
      int kind, span, dx, dy, k1, k2, sx, sy;
      segment_pair_type p;
      kind = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 30000 : 300;
      p.x1 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.y1 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.x2 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.y2 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.x3 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.y3 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.x4 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      p.y4 = FIELD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      dx = int'($urandom_range(0, 40)) - 20;
      dy = int'($urandom_range(0, 40)) - 20;
      k1 = int'($urandom_range(0, 20)) - 10;
      k2 = int'($urandom_range(0, 20)) - 10;
      sx = int'($urandom_range(0, 6)) - 3;
      sy = int'($urandom_range(0, 6)) - 3;
      case (kind)
         0, 1: begin
            // raw noise over the full range
            p = make_pair($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom);
         end
         2: begin
            // parallel, offset a little
            p.x2 = FIELD_BITS'(p.x1 + dx * 10); p.y2 = FIELD_BITS'(p.y1 + dy * 10);
            p.x3 = FIELD_BITS'(p.x1 + sx); p.y3 = FIELD_BITS'(p.y1 + sy);
            p.x4 = FIELD_BITS'(p.x3 + dx * k1); p.y4 = FIELD_BITS'(p.y3 + dy * k1);
         end
         3: begin
            // collinear, overlapping or not
            p.x2 = FIELD_BITS'(p.x1 + dx * 4); p.y2 = FIELD_BITS'(p.y1 + dy * 4);
            p.x3 = FIELD_BITS'(p.x1 + dx * k1); p.y3 = FIELD_BITS'(p.y1 + dy * k1);
            p.x4 = FIELD_BITS'(p.x1 + dx * k2); p.y4 = FIELD_BITS'(p.y1 + dy * k2);
         end
         4: begin
            // second segment starts on the first one's end point
            p.x3 = p.x2; p.y3 = p.y2;
         end
         5: begin
            // near-parallel with a tiny denominator, pushes the point far out
            p = make_pair(-32768, -32768, 32767, 32767 - $urandom_range(0, 2),
                          -32768, -32767, 32767, 32767 - $urandom_range(0, 2));
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_crossings.size() != 0);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      zero_thr = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus and phase control
   initial begin
      logic [THR_BITS-1:0] thresholds[7];
      thresholds = '{21'd1, 21'd0, 21'd1000, 21'd1048576, 21'h1FFFFF, 21'd37, 21'd1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: corner coordinates, each status, touching ends, clipping
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                        -32768, 32767, 32767, -32768));
      pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                        32767, 32767, 32767, 32767));
      pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                        -32768, -32768, -32768, -32768));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 0, 30, 0));
      pending_pairs.push_back(make_pair(0, 0, 1, 1, 5, 0, 5, 1));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
      pending_pairs.push_back(make_pair(-3, -7, 3, 7, -3, 7, 3, -7));
      pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                        -32768, -32767, 32767, 32767));
      pending_pairs.push_back(make_pair(-32768, 32767, 32767, -32768,
                                        -32767, 32767, 32767, -32767));
      pending_pairs.push_back(make_pair(1, 0, 2, 0, -32768, 1, 32767, 0));
      pending_pairs.push_back(make_pair(-1, -1, 0, 0, 3, 3, 4, 4));
      pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                        0, 0, 1, 1));

      foreach (thresholds[i]) begin
         if (i > 0) begin
            wait_idle();
            write_threshold(thresholds[i]);
         end
         quiet = (i == 6);
         repeat (200) pending_pairs.push_back(random_pair());
         // hold the result side off long enough to back the pipe up
         if (i == 2) begin
            repeat (20) @(posedge clock);
            hold_request = 1'b1;
         end
      end
      wait_idle();
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
